// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the controller modules.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ppid_pkg.sv -----
// Shared types and constants for the positional PID controller.
// Used by every module of the block; depends on nothing.
package ppid_pkg;

    localparam int DATA_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int GAIN_WIDTH      = 16;
    localparam int INTEG_WIDTH     = 12;
    localparam int INTEG_LIMIT     = 2000;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic signed [GAIN_WIDTH-1:0] gain_t;

    localparam cfg_index_t REG_GAIN_PROP  = 2'd0;
    localparam cfg_index_t REG_GAIN_INTEG = 2'd1;
    localparam cfg_index_t REG_GAIN_DERIV = 2'd2;

    localparam gain_t GAIN_PROP_RESET  = 16'sd614;
    localparam gain_t GAIN_INTEG_RESET = 16'sd41;
    localparam gain_t GAIN_DERIV_RESET = 16'sd41;

    typedef struct packed {
        gain_t prop;
        gain_t integ;
        gain_t deriv;
    } gains_t;

endpackage

// ----- rtl/positional_pid_with_clamps_top.sv -----
// Top level of the positional PID controller with integral and output clamps.
// Depends on ppid_pkg, ppid_front, ppid_mult and ppid_back.
//
// Channel   Signals                                 Direction
// sample    sample_valid/stall, measured, setpoint,   in
//           out_limit
// result    result_valid/stall, drive               out
// config    cfg_valid/ready, cfg_index, cfg_data    in
//
// One sample is accepted every cycle unless the result channel stalls; its result
// is registered in the error stage, the multiplier stage and the sum and clamp
// stage, one register each.
// Reset clears the gains to their defaults and the integral and previous error to zero.
// A stall on the result channel holds every filled stage; empty stages still fill.
// Configuration writes are always taken; index three is ignored.
module positional_pid_with_clamps_top #(
    parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ppid_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [DATA_WIDTH-1:0]   measured,
    input  logic signed [DATA_WIDTH-1:0]   setpoint,
    input  logic        [DATA_WIDTH-2:0]   out_limit,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [DATA_WIDTH-1:0]   drive,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  ppid_pkg::cfg_index_t           cfg_index,
    input  logic [ppid_pkg::GAIN_WIDTH-1:0] cfg_data
);
    import ppid_pkg::*;

    gains_t gains_reg;

    logic                                 f_valid;
    logic                                 f_stall;
    logic signed [DATA_WIDTH:0]           f_err;
    logic signed [INTEG_WIDTH-1:0]        f_integ;
    logic signed [DATA_WIDTH+1:0]         f_deriv;
    logic        [DATA_WIDTH-2:0]         f_limit;

    logic                                 m_valid;
    logic                                 m_stall;
    logic signed [GAIN_WIDTH+DATA_WIDTH:0]   m_prop;
    logic signed [GAIN_WIDTH+INTEG_WIDTH-1:0] m_integ;
    logic signed [GAIN_WIDTH+DATA_WIDTH+1:0] m_deriv;
    logic        [DATA_WIDTH-2:0]         m_limit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop  <= GAIN_PROP_RESET;
            gains_reg.integ <= GAIN_INTEG_RESET;
            gains_reg.deriv <= GAIN_DERIV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:  gains_reg.prop  <= cfg_data;
                REG_GAIN_INTEG: gains_reg.integ <= cfg_data;
                REG_GAIN_DERIV: gains_reg.deriv <= cfg_data;
                default:        ;
            endcase
        end
    end

    ppid_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sample_valid),
        .up_stall (sample_stall),
        .measured (measured),
        .setpoint (setpoint),
        .out_limit(out_limit),
        .dn_valid (f_valid),
        .dn_stall (f_stall),
        .err      (f_err),
        .integ    (f_integ),
        .deriv    (f_deriv),
        .limit    (f_limit)
    );

    ppid_mult #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gains_reg),
        .up_valid  (f_valid),
        .up_stall  (f_stall),
        .err       (f_err),
        .integ     (f_integ),
        .deriv     (f_deriv),
        .limit_in  (f_limit),
        .dn_valid  (m_valid),
        .dn_stall  (m_stall),
        .prod_prop (m_prop),
        .prod_integ(m_integ),
        .prod_deriv(m_deriv),
        .limit_out (m_limit)
    );

    ppid_back #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (m_valid),
        .up_stall  (m_stall),
        .prod_prop (m_prop),
        .prod_integ(m_integ),
        .prod_deriv(m_deriv),
        .limit_in  (m_limit),
        .dn_valid  (result_valid),
        .dn_stall  (result_stall),
        .drive     (drive)
    );

endmodule

// ----- rtl/ppid_front.sv -----
// First stage: error, clamped integral and derivative, with the controller state.
// Depends on ppid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppid_front #(
    parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   up_valid,
    output logic                                   up_stall,
    input  logic signed [DATA_WIDTH-1:0]           measured,
    input  logic signed [DATA_WIDTH-1:0]           setpoint,
    input  logic        [DATA_WIDTH-2:0]           out_limit,
    output logic                                   dn_valid,
    input  logic                                   dn_stall,
    output logic signed [DATA_WIDTH:0]             err,
    output logic signed [ppid_pkg::INTEG_WIDTH-1:0] integ,
    output logic signed [DATA_WIDTH+1:0]           deriv,
    output logic        [DATA_WIDTH-2:0]           limit
);
    import ppid_pkg::*;

    localparam int EW  = DATA_WIDTH + 1;
    localparam int IW  = INTEG_WIDTH;
    localparam int ISW = ((IW > EW) ? IW : EW) + 1;
    localparam int DW  = EW + 1;
    localparam logic signed [ISW-1:0] LIM_HI = ISW'(INTEG_LIMIT);
    localparam logic signed [ISW-1:0] LIM_LO = ISW'(-INTEG_LIMIT);

    logic                        valid_reg;
    logic signed [IW-1:0]        integ_sum_reg;
    logic signed [EW-1:0]        prev_error_reg;
    logic signed [EW-1:0]        err_reg;
    logic signed [IW-1:0]        integ_reg;
    logic signed [DW-1:0]        deriv_reg;
    logic        [DATA_WIDTH-2:0] limit_reg;

    logic signed [EW-1:0]  err_next;
    logic signed [ISW-1:0] integ_raw;
    logic signed [IW-1:0]  integ_next;
    logic signed [DW-1:0]  deriv_next;
    logic                  accept;

    assign up_stall = valid_reg && dn_stall;
    assign accept   = up_valid && !up_stall;

    assign err_next   = EW'(setpoint) - EW'(measured);
    assign integ_raw  = ISW'(integ_sum_reg) + ISW'(err_next);
    assign deriv_next = DW'(err_next) - DW'(prev_error_reg);

    always_comb
    begin
        if (integ_raw > LIM_HI)
        begin
            integ_next = IW'(LIM_HI);
        end
        else if (integ_raw < LIM_LO)
        begin
            integ_next = IW'(LIM_LO);
        end
        else
        begin
            integ_next = IW'(integ_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            integ_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (!up_stall)
            begin
                valid_reg <= up_valid;
            end
            if (accept)
            begin
                integ_sum_reg  <= integ_next;
                prev_error_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg   <= err_next;
            integ_reg <= integ_next;
            deriv_reg <= deriv_next;
            limit_reg <= out_limit;
        end
    end

    assign dn_valid = valid_reg;
    assign err      = err_reg;
    assign integ    = integ_reg;
    assign deriv    = deriv_reg;
    assign limit    = limit_reg;

    `PPID_ASSERT_IMP(a_integ_bound, clk, rst_n, 1'b1,
        (integ_sum_reg <= IW'(INTEG_LIMIT)) && (integ_sum_reg >= IW'(-INTEG_LIMIT)),
        "integral state outside its clamp range")
    `PPID_ASSERT_NXT(a_prev_error, clk, rst_n, accept,
        prev_error_reg == $past(err_next), "previous error not taken from accepted sample")
    `PPID_ASSERT_NXT(a_state_hold, clk, rst_n, !accept,
        $stable(integ_sum_reg) && $stable(prev_error_reg),
        "controller state changed without an accepted transaction")

endmodule

// ----- rtl/ppid_mult.sv -----
// Second stage: the three gain products, registered.
// Depends on ppid_pkg.
module ppid_mult #(
    parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF
) (
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  ppid_pkg::gains_t                                           gains,
    input  logic                                                       up_valid,
    output logic                                                       up_stall,
    input  logic signed [DATA_WIDTH:0]                                 err,
    input  logic signed [ppid_pkg::INTEG_WIDTH-1:0]                     integ,
    input  logic signed [DATA_WIDTH+1:0]                               deriv,
    input  logic        [DATA_WIDTH-2:0]                               limit_in,
    output logic                                                       dn_valid,
    input  logic                                                       dn_stall,
    output logic signed [ppid_pkg::GAIN_WIDTH+DATA_WIDTH:0]             prod_prop,
    output logic signed [ppid_pkg::GAIN_WIDTH+ppid_pkg::INTEG_WIDTH-1:0] prod_integ,
    output logic signed [ppid_pkg::GAIN_WIDTH+DATA_WIDTH+1:0]           prod_deriv,
    output logic        [DATA_WIDTH-2:0]                               limit_out
);
    import ppid_pkg::*;

    localparam int PW_P = GAIN_WIDTH + DATA_WIDTH + 1;
    localparam int PW_I = GAIN_WIDTH + INTEG_WIDTH;
    localparam int PW_D = GAIN_WIDTH + DATA_WIDTH + 2;

    logic                         valid_reg;
    logic signed [PW_P-1:0]       prop_reg;
    logic signed [PW_I-1:0]       integ_reg;
    logic signed [PW_D-1:0]       deriv_reg;
    logic        [DATA_WIDTH-2:0] limit_reg;
    logic                         accept;

    assign up_stall = valid_reg && dn_stall;
    assign accept   = up_valid && !up_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prop_reg  <= PW_P'(gains.prop) * PW_P'(err);
            integ_reg <= PW_I'(gains.integ) * PW_I'(integ);
            deriv_reg <= PW_D'(gains.deriv) * PW_D'(deriv);
            limit_reg <= limit_in;
        end
    end

    assign dn_valid   = valid_reg;
    assign prod_prop  = prop_reg;
    assign prod_integ = integ_reg;
    assign prod_deriv = deriv_reg;
    assign limit_out  = limit_reg;

endmodule

// ----- rtl/ppid_back.sv -----
// Third stage: sum of products, shift toward zero, output clamp and result register.
// Depends on ppid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppid_back #(
    parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ppid_pkg::FRAC_BITS_DEF
) (
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  logic                                                       up_valid,
    output logic                                                       up_stall,
    input  logic signed [ppid_pkg::GAIN_WIDTH+DATA_WIDTH:0]             prod_prop,
    input  logic signed [ppid_pkg::GAIN_WIDTH+ppid_pkg::INTEG_WIDTH-1:0] prod_integ,
    input  logic signed [ppid_pkg::GAIN_WIDTH+DATA_WIDTH+1:0]           prod_deriv,
    input  logic        [DATA_WIDTH-2:0]                               limit_in,
    output logic                                                       dn_valid,
    input  logic                                                       dn_stall,
    output logic signed [DATA_WIDTH-1:0]                               drive
);
    import ppid_pkg::*;

    localparam int SUMW = GAIN_WIDTH + DATA_WIDTH + 4;

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg;

    logic signed [SUMW-1:0]       sum;
    logic                         neg;
    logic        [SUMW-1:0]       mag;
    logic        [SUMW-1:0]       shifted;
    logic        [DATA_WIDTH-2:0] res_mag;
    logic signed [DATA_WIDTH-1:0] drive_next;
    logic                         accept;

    assign up_stall = valid_reg && dn_stall;
    assign accept   = up_valid && !up_stall;

    assign sum     = SUMW'(prod_prop) + SUMW'(prod_integ) + SUMW'(prod_deriv);
    assign neg     = sum[SUMW-1];
    assign mag     = neg ? SUMW'(-sum) : SUMW'(sum);
    assign shifted = mag >> FRAC_BITS;
    assign res_mag = (shifted > SUMW'(limit_in)) ? limit_in : shifted[DATA_WIDTH-2:0];

    always_comb
    begin
        if (neg)
        begin
            drive_next = -$signed({1'b0, res_mag});
        end
        else
        begin
            drive_next = $signed({1'b0, res_mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
        end
    end

    assign dn_valid = valid_reg;
    assign drive    = drive_reg;

    `PPID_ASSERT_NXT(a_drive_clamp, clk, rst_n, accept,
        (drive_reg <= $signed({1'b0, $past(limit_in)}))
            && (drive_reg >= -$signed({1'b0, $past(limit_in)})),
        "drive outside the limit of its transaction")
    `PPID_ASSERT_NXT(a_zero_limit, clk, rst_n, accept && (limit_in == '0),
        drive_reg == '0, "zero limit did not give zero drive")
    `PPID_ASSERT_NXT(a_result_held, clk, rst_n, valid_reg && dn_stall,
        valid_reg && $stable(drive_reg), "stalled result lost or changed")

endmodule

// ----- dv/tb_positional_pid_with_clamps_top.sv -----
// Self-checking testbench for positional_pid_with_clamps_top: drives control samples and
// gain writes, predicts every drive value and compares them in order of arrival.
// Depends on ppid_pkg and the RTL of the controller; needs no files or arguments.
module tb_positional_pid_with_clamps_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppid_pkg::*;

    localparam int SHIFT = FRAC_BITS_DEF;
    localparam cfg_index_t REG_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 125;

    class pid_tracker;
        gain_t kp;
        gain_t ki;
        gain_t kd;
        logic signed [INTEG_WIDTH-1:0] integ_acc;
        logic signed [16:0] prev_err;
        logic signed [15:0] drive_due[$];
        int faults;
        int compared;

        function new();
            kp = GAIN_PROP_RESET;
            ki = GAIN_INTEG_RESET;
            kd = GAIN_DERIV_RESET;
            integ_acc = '0;
            prev_err = '0;
            faults = 0;
            compared = 0;
        endfunction

        function void load_gain(cfg_index_t idx, gain_t val);
            case (idx)
                REG_GAIN_PROP:  kp = val;
                REG_GAIN_INTEG: ki = val;
                REG_GAIN_DERIV: kd = val;
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [15:0] meas, logic signed [15:0] target,
                                  logic [14:0] lim);
            longint err;
            longint acc;
            longint slope;
            longint total;
            longint outv;
            err = longint'(target) - longint'(meas);
            acc = longint'(integ_acc) + err;
            if (acc > INTEG_LIMIT)
                acc = INTEG_LIMIT;
            if (acc < -INTEG_LIMIT)
                acc = -INTEG_LIMIT;
            integ_acc = acc[INTEG_WIDTH-1:0];
            slope = err - longint'(prev_err);
            prev_err = err[16:0];
            total = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * slope;
            if (total < 0)
                outv = -((-total) >> SHIFT);
            else
                outv = total >> SHIFT;
            if (outv > longint'(lim))
                outv = longint'(lim);
            if (outv < -longint'(lim))
                outv = -longint'(lim);
            drive_due.push_back(outv[15:0]);
        endfunction

        function void check_drive(logic signed [15:0] got);
            logic signed [15:0] want;
            if (drive_due.size() == 0)
            begin
                $display("%0t: drive %0d arrived with no sample outstanding", $time, got);
                faults++;
            end
            else
            begin
                want = drive_due.pop_front();
                compared++;
                if (got !== want)
                begin
                    $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
                    faults++;
                end
            end
        endfunction

        function int pending();
            return drive_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [15:0] measured = '0;
    logic signed [15:0] setpoint = '0;
    logic [14:0] out_limit = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [15:0] drive;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = REG_GAIN_PROP;
    logic [GAIN_WIDTH-1:0] cfg_data = '0;

    pid_tracker tracker;
    bit idling = 1'b1;
    int stall_left = 0;
    int samples_sent = 0;
    int settings_used = 1;

    positional_pid_with_clamps_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .measured     (measured),
        .setpoint     (setpoint),
        .out_limit    (out_limit),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive        (drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_drive(drive);
    end

    task automatic send_sample(logic signed [15:0] meas, logic signed [15:0] target,
                               logic [14:0] lim);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        measured <= meas;
        setpoint <= target;
        out_limit <= lim;
        do @(posedge clk); while (sample_stall);
        tracker.take_sample(meas, target, lim);
        samples_sent++;
    endtask

    task automatic send_random();
        logic signed [15:0] target;
        logic signed [15:0] meas;
        logic [14:0] lim;
        int kind;
        kind = $urandom_range(0, 9);
        target = 16'($urandom);
        if (kind < 7)
            meas = target - 16'(int'($urandom_range(0, 600)) - 300);
        else
            meas = 16'($urandom);
        if (kind == 9)
            lim = 15'($urandom_range(0, 3));
        else if ($urandom_range(0, 1) == 0)
            lim = 15'($urandom_range(0, 400));
        else
            lim = 15'($urandom);
        send_sample(meas, target, lim);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gains(gain_t p, gain_t i, gain_t d);
        cfg_index_t idx;
        gain_t val;
        for (int n = 0; n < 4; n++)
        begin
            case (n)
                0: begin idx = REG_GAIN_PROP;  val = p; end
                1: begin idx = REG_SPARE;      val = gain_t'($urandom); end
                2: begin idx = REG_GAIN_INTEG; val = i; end
                default: begin idx = REG_GAIN_DERIV; val = d; end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            do @(posedge clk); while (!cfg_ready);
            tracker.load_gain(idx, val);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_positional_pid_with_clamps_top: errors");
        $finish;
    end

    initial
    begin
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd0, 16'sd0, 15'h7fff);
        send_sample(-16'sd32768, 16'sd32767, 15'h7fff);
        send_sample(16'sd32767, -16'sd32768, 15'h7fff);
        send_sample(16'sd32767, -16'sd32768, 15'd0);
        send_sample(-16'sd32768, 16'sd32767, 15'd0);
        send_sample(-16'sd32768, 16'sd32767, 15'd1);
        send_sample(16'sd0, 16'sd0, 15'd0);
        send_sample(16'sd1, 16'sd0, 15'h7fff);
        send_sample(16'sd10, 16'sd0, 15'h7fff);
        send_sample(16'sd0, 16'sd10, 15'h7fff);
        repeat (5) send_sample(16'sd0, 16'sd1000, 15'h7fff);
        repeat (6) send_sample(16'sd500, -16'sd500, 15'h7fff);
        send_sample(-16'sd1, 16'sd0, 15'h5555);
        send_sample(16'sd12345, -16'sd12345, 15'h2aaa);
        send_sample(16'sd0, 16'sd0, 15'h7fff);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_gains(16'sh7fff, 16'sh7fff, 16'sh7fff);
                1: write_gains(-16'sh8000, -16'sh8000, -16'sh8000);
                2: write_gains(16'sh0000, 16'sh0000, 16'sh0000);
                3: write_gains(16'sh7fff, -16'sh8000, 16'sh0000);
                4: write_gains(GAIN_PROP_RESET, GAIN_INTEG_RESET, GAIN_DERIV_RESET);
                default: write_gains(gain_t'($urandom), gain_t'($urandom), gain_t'($urandom));
            endcase
            if (p == PHASES - 1)
                idling = 1'b0;
            repeat (PHASE_ITEMS) send_random();
            settle();
        end

        $display("Drove %0d samples over %0d gain settings; %0d drive values compared.",
                 samples_sent, settings_used, tracker.compared);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("tb_positional_pid_with_clamps_top: clean");
        else
            $display("tb_positional_pid_with_clamps_top: errors");
        $finish;
    end
endmodule
